>>> rtl/bds_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and register indexes of the 2x2 box downsampler.
package bds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;                    // one color channel
    localparam int PAIR_W  = PIX_W + 1;            // sum of two channel values
    localparam int SUM_W   = PIX_W + 2;            // sum of four channel values
    localparam int LINE_W  = 3 * SUM_W;            // one line store entry

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int EW_W    = COL_W + 1;            // holds MAX_WIDTH itself
    localparam int EH_W    = ROW_W + 1;            // holds MAX_HEIGHT itself

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 8;

    localparam int TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [EW_W-1:0] WIDTH_RESET  = EW_W'(256);
    localparam logic [EH_W-1:0] HEIGHT_RESET = EH_W'(256);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // Where the current beat sits in the frame.
    typedef struct packed {
        logic               col_odd;
        logic               row_odd;
        logic               col_last;
        logic               row_last;
        logic [LINE_AW-1:0] idx;
    } pos_t;

    // Clear the low bit, then clamp to 2..MAX_WIDTH.
    function automatic logic [EW_W-1:0] eff_width(input logic [CFG_WIDTH_W-1:0] v);
        logic [CFG_WIDTH_W-1:0] v_even;
        logic [EW_W-1:0]        res;
        v_even = {v[CFG_WIDTH_W-1:1], 1'b0};
        if (v_even < CFG_WIDTH_W'(2)) begin
            res = EW_W'(2);
        end else if (32'(v_even) > MAX_WIDTH) begin
            res = EW_W'(MAX_WIDTH);
        end else begin
            res = EW_W'(v_even);
        end
        return res;
    endfunction

    // Clear the low bit, then clamp to 2..MAX_HEIGHT.
    function automatic logic [EH_W-1:0] eff_height(input logic [CFG_HEIGHT_W-1:0] v);
        logic [CFG_HEIGHT_W-1:0] v_even;
        logic [EH_W-1:0]         res;
        v_even = {v[CFG_HEIGHT_W-1:1], 1'b0};
        if (v_even < CFG_HEIGHT_W'(2)) begin
            res = EH_W'(2);
        end else if (32'(v_even) > MAX_HEIGHT) begin
            res = EH_W'(MAX_HEIGHT);
        end else begin
            res = EH_W'(v_even);
        end
        return res;
    endfunction

endpackage

>>> rtl/bds_line_ram.sv
`timescale 1ns / 1ps
// Line store of horizontal pair sums: one write port, one registered read port.
module bds_line_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [bds_pkg::LINE_AW-1:0] wr_addr,
    input  logic [bds_pkg::LINE_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [bds_pkg::LINE_AW-1:0] rd_addr,
    output logic [bds_pkg::LINE_W-1:0]  rd_data
);

    logic [bds_pkg::LINE_W-1:0] mem [bds_pkg::LINE_DEPTH];
    logic [bds_pkg::LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read until the next read strobe.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bds_ctrl.sv
`timescale 1ns / 1ps
// Size registers and the column/row counters that place each beat in the frame.
module bds_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           advance,
    output bds_pkg::pos_t                  pos
);

    logic [bds_pkg::EW_W-1:0]  width_reg,  width_next;
    logic [bds_pkg::EH_W-1:0]  height_reg, height_next;
    logic [bds_pkg::COL_W-1:0] col_reg,    col_next;
    logic [bds_pkg::ROW_W-1:0] row_reg,    row_next;
    logic                      col_last;
    logic                      row_last;

    // Store the clamped sizes so the per-beat compare stays short.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid) begin
            if (cfg_index == bds_pkg::CFG_IMAGE_WIDTH) begin
                width_next = bds_pkg::eff_width(cfg_data[bds_pkg::CFG_WIDTH_W-1:0]);
            end else if (cfg_index == bds_pkg::CFG_IMAGE_HEIGHT) begin
                height_next = bds_pkg::eff_height(cfg_data[bds_pkg::CFG_HEIGHT_W-1:0]);
            end
        end
    end

    assign col_last = ({1'b0, col_reg} + bds_pkg::EW_W'(1)) >= width_reg;
    assign row_last = ({1'b0, row_reg} + bds_pkg::EH_W'(1)) >= height_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + bds_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + bds_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bds_pkg::WIDTH_RESET;
            height_reg <= bds_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign pos.col_odd  = col_reg[0];
    assign pos.row_odd  = row_reg[0];
    assign pos.col_last = col_last;
    assign pos.row_last = row_last;
    assign pos.idx      = col_reg[bds_pkg::COL_W-1:1];

endmodule

>>> rtl/bds_avg.sv
`timescale 1ns / 1ps
// Pair sums, line store traffic and the four-pixel mean into the result register.
module bds_avg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  bds_pkg::pixel_t             pixel,
    input  bds_pkg::pos_t               pos,
    input  logic                        out_ready,
    output logic                        ram_wr_en,
    output logic [bds_pkg::LINE_W-1:0]  ram_wr_data,
    output logic                        ram_rd_en,
    output logic [bds_pkg::LINE_AW-1:0] ram_addr,
    input  logic [bds_pkg::LINE_W-1:0]  ram_rd_data,
    output logic                        out_valid,
    output bds_pkg::pixel_t             out_pixel,
    output logic                        out_last
);

    localparam int SW = bds_pkg::SUM_W;

    bds_pkg::pixel_t           held_reg;
    logic [bds_pkg::PAIR_W-1:0] pr, pg, pb;
    logic [SW-1:0]             sr, sg, sb;
    logic                      produce;
    logic                      valid_reg, valid_next;
    bds_pkg::pixel_t           pix_reg;
    logic                      last_reg;

    // Capture the even-column pixel of each pair.
    always_ff @(posedge aclk) begin
        if (accept && !pos.col_odd) begin
            held_reg <= pixel;
        end
    end

    assign pr = {1'b0, held_reg.red}   + {1'b0, pixel.red};
    assign pg = {1'b0, held_reg.green} + {1'b0, pixel.green};
    assign pb = {1'b0, held_reg.blue}  + {1'b0, pixel.blue};

    // Even rows store the pair sum; odd rows fetch it one beat early.
    assign ram_addr    = pos.idx;
    assign ram_wr_en   = accept && pos.col_odd && !pos.row_odd;
    assign ram_wr_data = {SW'(pr), SW'(pg), SW'(pb)};
    assign ram_rd_en   = accept && !pos.col_odd && pos.row_odd;

    assign sr = ram_rd_data[3*SW-1:2*SW] + SW'(pr);
    assign sg = ram_rd_data[2*SW-1:SW]   + SW'(pg);
    assign sb = ram_rd_data[SW-1:0]      + SW'(pb);

    assign produce = accept && pos.col_odd && pos.row_odd;

    always_comb begin
        valid_next = valid_reg;
        if (produce) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            pix_reg.red   <= sr[SW-1:2];
            pix_reg.green <= sg[SW-1:2];
            pix_reg.blue  <= sb[SW-1:2];
            last_reg      <= pos.col_last && pos.row_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pix_reg;
    assign out_last  = last_reg;

endmodule

>>> rtl/box_downsample_2x2_rgb.sv
`timescale 1ns / 1ps
// Top level of the 2x2 box-filter RGB downsampler.
// A block's result beat is registered and appears in the cycle after its bottom-right pixel's beat.
// Throughput: 1 input beat per cycle unless a result beat stalls; one result per four input pixels
// (odd column, odd row). The line store port serves one read or one write per beat.
// Reset (aresetn low, synchronous): counters to zero, width and height to 256, result register empty.
// The line store is not cleared; reads hit entries written one row up while the width is unchanged.
module box_downsample_2x2_rgb (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input pixel stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bds_pkg::TDATA_W-1:0]    s_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
    // downsampled stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bds_pkg::TDATA_W-1:0]    m_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic                           m_tlast,   // frame_last
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                        s_accept;
    bds_pkg::pixel_t             in_pixel;
    bds_pkg::pos_t               pos;
    logic                        ram_wr_en;
    logic [bds_pkg::LINE_W-1:0]  ram_wr_data;
    logic                        ram_rd_en;
    logic [bds_pkg::LINE_AW-1:0] ram_addr;
    logic [bds_pkg::LINE_W-1:0]  ram_rd_data;
    bds_pkg::pixel_t             out_pixel;

    // Size registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    // Take a new beat whenever the result register is empty or draining this cycle.
    assign s_tready = !m_tvalid || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign in_pixel.red   = s_tdata[7:0];
    assign in_pixel.green = s_tdata[15:8];
    assign in_pixel.blue  = s_tdata[23:16];

    // Track column and row; advance once per accepted beat.
    bds_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (s_accept),
        .pos       (pos)
    );

    // One row of pair sums, half the maximum width deep.
    bds_line_ram u_line (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    // Sum the block and hold the mean until the sink takes it.
    bds_avg u_avg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .pixel       (in_pixel),
        .pos         (pos),
        .out_ready   (m_tready),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_addr    (ram_addr),
        .ram_rd_data (ram_rd_data),
        .out_valid   (m_tvalid),
        .out_pixel   (out_pixel),
        .out_last    (m_tlast)
    );

    assign m_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};

endmodule

>>> rtl/bds_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the downsampler, bound to the top level.
module bds_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bds_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat pending after reset");

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // An empty result register never stalls the input.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Every fresh result beat comes from an input beat accepted in the previous cycle.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid && !m_tready) |-> $past(s_tvalid && s_tready))
        else $error("result beat without an input beat");

endmodule

bind box_downsample_2x2_rgb bds_checker u_bds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> sim/box_downsample_2x2_rgb_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 2x2 box-filter RGB downsampler.
module box_downsample_2x2_rgb_tb;

    // Run sizing: about 1.9k pixel beats in all. Even the slowest legal run
    // (source gaps, sink stalls per result, the long sink hold, idle waits)
    // stays well within CYCLE_LIMIT.
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int unsigned DRAIN_LIMIT      = 20_000;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PIXELS    = 1350;
    localparam int unsigned CALM_FROM        = 1150;  // no idling past this point
    localparam int unsigned HOLD_PHASE       = 3;
    localparam int unsigned DRAIN_PHASE      = 5;
    localparam int unsigned WIDE_PHASE       = 8;
    localparam int unsigned LINE_SLOTS       = bds_pkg::MAX_WIDTH / 2;

    // Register indexes the block must ignore.
    localparam logic [bds_pkg::CFG_IDX_W-1:0] CFG_INDEX_UNUSED_LO = bds_pkg::CFG_IDX_W'(2);
    localparam logic [bds_pkg::CFG_IDX_W-1:0] CFG_INDEX_UNUSED_HI = bds_pkg::CFG_IDX_W'(255);

    typedef enum logic {STEP_REG, STEP_PIXELS} plan_kind_t;

    // One row of the directed plan: a register write, or a run of equal pixels.
    // Where typed is set, every result of the run must equal mean/last.
    typedef struct packed {
        plan_kind_t                     kind;
        logic [bds_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [bds_pkg::CFG_DATA_W-1:0] reg_value;
        bds_pkg::pixel_t                px;
        logic [11:0]                    count;
        logic                           typed;
        bds_pkg::pixel_t                mean;
        logic                           last;
    } plan_step_t;

    typedef struct packed {
        logic [bds_pkg::SUM_W-1:0] red;
        logic [bds_pkg::SUM_W-1:0] green;
        logic [bds_pkg::SUM_W-1:0] blue;
    } pair_sums_t;

    typedef struct packed {
        bds_pkg::pixel_t mean;
        logic            last;
    } block_mean_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bds_pkg::TDATA_W-1:0]    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bds_pkg::TDATA_W-1:0]    m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bds_pkg::CFG_DATA_W-1:0] cfg_data;

    // Mirror of the block's settings and frame position.
    logic [bds_pkg::CFG_WIDTH_W-1:0]  width_reg  = bds_pkg::CFG_WIDTH_W'(256);
    logic [bds_pkg::CFG_HEIGHT_W-1:0] height_reg = bds_pkg::CFG_HEIGHT_W'(256);
    int unsigned                      px_col = 0;
    int unsigned                      px_row = 0;
    bds_pkg::pixel_t                  held_px = '0;
    pair_sums_t                       pair_line [LINE_SLOTS];

    block_mean_t block_means_q[$];
    plan_step_t  plan_q[$];

    bit          calm = 1'b0;           // stop all idling near the end
    bit          sink_hold_req = 1'b0;  // ask the sink for one long hold
    int unsigned src_steady = 0;        // beats left in a gap-free stretch
    int unsigned cycle_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned means_seen = 0;
    int unsigned frames_closed = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;

    box_downsample_2x2_rgb dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // in_red[7:0], in_green[15:8], in_blue[23:16]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_red[7:0], out_green[15:8], out_blue[23:16]
        .m_tlast   (m_tlast),   // frame_last
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Work out the 2x2 mean this pixel completes, if any, and advance the
    // frame position. Sizes: clear the low bit, clamp to 2..max.
    function automatic bit advance_block_mean(input bds_pkg::pixel_t px,
                                              output bds_pkg::pixel_t mean,
                                              output logic last);
        int unsigned  w;
        int unsigned  h;
        int unsigned  slot;
        logic [bds_pkg::SUM_W-1:0] pr, pg, pb;
        logic [bds_pkg::SUM_W-1:0] sr, sg, sb;
        bit           got;
        w = int'(width_reg) & ~1;
        h = int'(height_reg) & ~1;
        if (w < 2) w = 2;
        if (w > bds_pkg::MAX_WIDTH) w = bds_pkg::MAX_WIDTH;
        if (h < 2) h = 2;
        if (h > bds_pkg::MAX_HEIGHT) h = bds_pkg::MAX_HEIGHT;
        slot = (px_col >> 1) % LINE_SLOTS;
        got  = 1'b0;
        mean = '0;
        last = 1'b0;
        if ((px_col & 1) == 0) begin
            held_px = px;
        end else begin
            pr = bds_pkg::SUM_W'(held_px.red)   + bds_pkg::SUM_W'(px.red);
            pg = bds_pkg::SUM_W'(held_px.green) + bds_pkg::SUM_W'(px.green);
            pb = bds_pkg::SUM_W'(held_px.blue)  + bds_pkg::SUM_W'(px.blue);
            if ((px_row & 1) == 0) begin
                // even row: park the pair sums for the row below
                pair_line[slot] = {pr, pg, pb};
            end else begin
                sr = pair_line[slot].red   + pr;
                sg = pair_line[slot].green + pg;
                sb = pair_line[slot].blue  + pb;
                mean.red   = sr[bds_pkg::SUM_W-1:2];
                mean.green = sg[bds_pkg::SUM_W-1:2];
                mean.blue  = sb[bds_pkg::SUM_W-1:2];
                last = (px_col + 1 >= w) && (px_row + 1 >= h);
                got  = 1'b1;
            end
        end
        // wrap as soon as the next position reaches the current size
        if (px_col + 1 >= w) begin
            px_col = 0;
            px_row = (px_row + 1 >= h) ? 0 : px_row + 1;
        end else begin
            px_col++;
        end
        return got;
    endfunction

    function automatic void check_field(input string label, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    function automatic void plan_reg(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [bds_pkg::CFG_DATA_W-1:0] val);
        plan_step_t st;
        st = '0;
        st.kind      = STEP_REG;
        st.reg_index = idx;
        st.reg_value = val;
        plan_q = {plan_q, st};
    endfunction

    function automatic void plan_pixels(input bds_pkg::pixel_t px, input int unsigned n,
                                        input bit typed, input bds_pkg::pixel_t mean,
                                        input logic last);
        plan_step_t st;
        st = '0;
        st.kind  = STEP_PIXELS;
        st.px    = px;
        st.count = 12'(n);
        st.typed = typed;
        st.mean  = mean;
        st.last  = last;
        plan_q = {plan_q, st};
    endfunction

    // Hold the source until every predicted mean is out, then let the
    // pipeline settle so a register write lands on an idle block.
    task automatic wait_block_idle();
        s_tvalid = 1'b0;
        while (block_means_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bds_pkg::CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == bds_pkg::CFG_IMAGE_WIDTH)
            width_reg = val[bds_pkg::CFG_WIDTH_W-1:0];
        else if (idx == bds_pkg::CFG_IMAGE_HEIGHT)
            height_reg = val[bds_pkg::CFG_HEIGHT_W-1:0];
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Offer one pixel beat; on acceptance queue the mean it completes. A typed
    // expectation replaces the predicted value but the mirror still advances.
    task automatic send_pixel(input bds_pkg::pixel_t px, input bit typed,
                              input bds_pkg::pixel_t typed_mean, input logic typed_last);
        bds_pkg::pixel_t mean;
        logic            last;
        block_mean_t     bm;
        if (!calm) begin
            if (src_steady != 0) begin
                src_steady--;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        s_tvalid = 1'b0;
                        repeat ($urandom_range(1, 12)) @(negedge aclk);
                    end
                    3: src_steady = $urandom_range(20, 80);
                    default: ;
                endcase
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = {px.blue, px.green, px.red};
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        if (advance_block_mean(px, mean, last)) begin
            if (typed) begin
                mean = typed_mean;
                last = typed_last;
            end
            bm.mean = mean;
            bm.last = last;
            block_means_q = {block_means_q, bm};
        end
        @(negedge aclk);
    endtask

    // Sink pacing: random stall bursts, gap-free stretches, one long hold.
    initial begin : sink_pacing
        int unsigned held;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_tready = 1'b0;
                for (held = 0; held < SINK_HOLD_CYCLES; held++) @(negedge aclk);
                sink_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
        end
    end

    // Compare every result beat with the oldest predicted mean.
    always @(posedge aclk) begin : mean_checker
        block_mean_t want;
        if (aresetn && m_tvalid && m_tready) begin
            means_seen++;
            if (m_tlast) frames_closed++;
            if (block_means_q.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, got %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = block_means_q.pop_front();
                check_field("red",   want.mean.red,   m_tdata[7:0]);
                check_field("green", want.mean.green, m_tdata[15:8]);
                check_field("blue",  want.mean.blue,  m_tdata[23:16]);
                check_field("last",  8'(want.last),   8'(m_tlast));
            end
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned k;
        int unsigned n;
        int unsigned phase_no;
        int unsigned random_pixels;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        phase_no      = 0;
        random_pixels = 0;

        // Reset size 256x256: a flat row pair gives 128 equal means, none last.
        plan_pixels({8'd10, 8'd20, 8'd30}, 256, 1'b0, '0, 1'b0);
        plan_pixels({8'd10, 8'd20, 8'd30}, 256, 1'b1, {8'd10, 8'd20, 8'd30}, 1'b0);
        // Shrink height mid-frame on row 2: that row wraps straight to row 0.
        plan_reg(bds_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        plan_reg(bds_pkg::CFG_IMAGE_WIDTH, 13'd3);
        plan_pixels({8'd255, 8'd255, 8'd255}, 4, 1'b0, '0, 1'b0);
        plan_pixels({8'd255, 8'd255, 8'd255}, 2, 1'b1, {8'd255, 8'd255, 8'd255}, 1'b1);
        plan_pixels({8'd0, 8'd0, 8'd0}, 4, 1'b1, {8'd0, 8'd0, 8'd0}, 1'b1);
        // Truncation: 3+3+3+2 = 11, quarter is 2.
        plan_pixels({8'd3, 8'd3, 8'd3}, 3, 1'b0, '0, 1'b0);
        plan_pixels({8'd2, 8'd2, 8'd2}, 1, 1'b1, {8'd2, 8'd2, 8'd2}, 1'b1);
        // Sizes below two clamp up to two.
        plan_reg(bds_pkg::CFG_IMAGE_WIDTH, 13'd1);
        plan_reg(bds_pkg::CFG_IMAGE_HEIGHT, 13'd0);
        plan_pixels({8'd255, 8'd128, 8'd1}, 4, 1'b1, {8'd255, 8'd128, 8'd1}, 1'b1);
        // Unknown indexes must not touch either size.
        plan_reg(CFG_INDEX_UNUSED_LO, 13'h1FFF);
        plan_reg(CFG_INDEX_UNUSED_HI, 13'h1FFF);
        plan_pixels({8'hAA, 8'h55, 8'hAA}, 4, 1'b1, {8'hAA, 8'h55, 8'hAA}, 1'b1);
        // Height above the top clamps to 4096, so no frame end here.
        plan_reg(bds_pkg::CFG_IMAGE_WIDTH, 13'd4);
        plan_reg(bds_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
        plan_pixels({8'd7, 8'd7, 8'd7}, 8, 1'b1, {8'd7, 8'd7, 8'd7}, 1'b0);
        // Resize on row 2 of a tall frame; rows 2 and 3 close it.
        plan_reg(bds_pkg::CFG_IMAGE_HEIGHT, 13'd4);
        plan_reg(bds_pkg::CFG_IMAGE_WIDTH, 13'd6);
        plan_pixels({8'd9, 8'd200, 8'd77}, 12, 1'b0, '0, 1'b0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Walk the directed plan.
        for (i = 0; i < plan_q.size(); i++) begin
            if (plan_q[i].kind == STEP_REG) begin
                wait_block_idle();
                write_reg(plan_q[i].reg_index, plan_q[i].reg_value);
            end else begin
                for (k = 0; k < plan_q[i].count; k++)
                    send_pixel(plan_q[i].px, plan_q[i].typed, plan_q[i].mean, plan_q[i].last);
            end
        end

        // Random phases. Each starts at column 0 of an even row, so every odd
        // row reads line entries written by the row above at the same width.
        while (random_pixels < RANDOM_PIXELS) begin
            phase_no++;
            if (phase_no == WIDE_PHASE) begin
                // One full wide frame of two rows: drop height to 2, run to
                // the frame start, then widen with a random low bit.
                wait_block_idle();
                write_reg(bds_pkg::CFG_IMAGE_HEIGHT, 13'd2);
                while (px_col != 0 || px_row != 0) begin
                    send_pixel(bds_pkg::pixel_t'(24'($urandom)), 1'b0, '0, 1'b0);
                    random_pixels++;
                end
                wait_block_idle();
                n = 2 * $urandom_range(100, 150);
                write_reg(bds_pkg::CFG_IMAGE_WIDTH,
                          {2'($urandom), 11'(n) | 11'($urandom_range(0, 1))});
                for (k = 0; k < 2 * n; k++) begin
                    send_pixel(bds_pkg::pixel_t'(24'($urandom)), 1'b0, '0, 1'b0);
                    random_pixels++;
                    if (random_pixels >= CALM_FROM)
                        calm = 1'b1;
                end
            end else begin
                if (!calm && $urandom_range(0, 2) != 0) begin
                    wait_block_idle();
                    if ($urandom_range(0, 3) != 0)
                        write_reg(bds_pkg::CFG_IMAGE_WIDTH,
                                  {2'($urandom), 11'($urandom_range(0, 40))});
                    if ($urandom_range(0, 3) != 0)
                        write_reg(bds_pkg::CFG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0)
                                  ? 13'($urandom_range(4096, 8191))
                                  : 13'($urandom_range(0, 12)));
                    if ($urandom_range(0, 9) == 0)
                        write_reg(bds_pkg::CFG_IDX_W'($urandom_range(CFG_INDEX_UNUSED_LO,
                                                                     CFG_INDEX_UNUSED_HI)),
                                  13'($urandom));
                end
                // Stall the sink long enough to back up the input side.
                if (phase_no == HOLD_PHASE)
                    sink_hold_req = 1'b1;
                n = (phase_no == HOLD_PHASE) ? 150 : $urandom_range(8, 120);
                for (k = 0; k < n || px_col != 0 || (px_row & 1) != 0; k++) begin
                    if (phase_no == DRAIN_PHASE && k == n / 2)
                        wait_block_idle();
                    send_pixel(bds_pkg::pixel_t'(24'($urandom)), 1'b0, '0, 1'b0);
                    random_pixels++;
                    if (random_pixels >= CALM_FROM)
                        calm = 1'b1;
                end
            end
        end

        // Drain, settle, then report.
        s_tvalid = 1'b0;
        for (k = 0; k < DRAIN_LIMIT && block_means_q.size() != 0; k++) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (block_means_q.size() != 0) begin
            mismatches += block_means_q.size();
            $display("%0t: %0d expected means never arrived, next expected %h",
                     $time, block_means_q.size(), block_means_q[0]);
        end
        $display("Sent %0d pixel beats over %0d register writes; checked %0d block means,",
                 pixels_sent, reg_writes, means_seen);
        $display("%0d of them frame ends, %0d mismatches.", frames_closed, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
